FILE: src/cubic_bezier_evaluator_core_defines.svh
// Assertion macros for the checker of the cubic Bezier evaluator.
// Macros use clk from the scope where used; all but CBE_ASSERT_RST also rst_n.
`ifndef CUBIC_BEZIER_EVALUATOR_CORE_DEFINES_SVH
`define CUBIC_BEZIER_EVALUATOR_CORE_DEFINES_SVH

// Same-cycle implication, switched off while reset is held.
`define CBE_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cbe check failed");

// Next-cycle implication, switched off while reset is held.
`define CBE_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cbe check failed");

// Next-cycle implication that also holds across reset.
`define CBE_ASSERT_RST(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("cbe check failed");

`endif

FILE: src/cbe_pkg.sv
// Package for the cubic Bezier evaluator: payload types, Bernstein coefficient
// table and the Q16.16 multiply helpers. No dependencies.
package cbe_pkg;

  localparam int NUM_PTS   = 4;
  localparam int NUM_REGS  = 2 * NUM_PTS;
  localparam int ADDR_W    = 5;
  localparam int NUM_STG   = 5;

  typedef enum logic [1:0] {
    KIND_POS  = 2'd0,
    KIND_VEL  = 2'd1,
    KIND_ACC  = 2'd2,
    KIND_JERK = 2'd3
  } kind_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [16:0] t;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
  } out_item_t;

  // Coefficients in whole units; the table entry is scaled by 2^16 on use.
  localparam logic signed [5:0] COEF [4][4][4] = '{
    '{ '{-6'sd1,  6'sd3,  -6'sd3,  6'sd1},
       '{ 6'sd3, -6'sd6,   6'sd3,  6'sd0},
       '{-6'sd3,  6'sd3,   6'sd0,  6'sd0},
       '{ 6'sd1,  6'sd0,   6'sd0,  6'sd0} },
    '{ '{ 6'sd0, -6'sd3,   6'sd6, -6'sd3},
       '{ 6'sd0,  6'sd9, -6'sd12,  6'sd3},
       '{ 6'sd0, -6'sd9,   6'sd6,  6'sd0},
       '{ 6'sd0,  6'sd3,   6'sd0,  6'sd0} },
    '{ '{ 6'sd0,  6'sd0,  -6'sd6,  6'sd6},
       '{ 6'sd0,  6'sd0,  6'sd18, -6'sd12},
       '{ 6'sd0,  6'sd0, -6'sd18,  6'sd6},
       '{ 6'sd0,  6'sd0,   6'sd6,  6'sd0} },
    '{ '{ 6'sd0,  6'sd0,   6'sd0, -6'sd6},
       '{ 6'sd0,  6'sd0,   6'sd0,  6'sd18},
       '{ 6'sd0,  6'sd0,   6'sd0, -6'sd18},
       '{ 6'sd0,  6'sd0,   6'sd0,  6'sd6} }
  };

  function automatic logic signed [31:0] coef_q(input logic [1:0] kind,
                                                input logic [1:0] idx,
                                                input logic [1:0] step);
    logic signed [5:0] c;
    c = COEF[kind][idx][step];
    return {{10{c[5]}}, c, 16'h0000};
  endfunction

  // Weight times parameter: floor of the product over 2^16, low 32 bits.
  function automatic logic signed [31:0] qmul_t(input logic signed [31:0] a,
                                                input logic [16:0] b);
    logic signed [49:0] p;
    p = $signed({{18{a[31]}}, a}) * $signed({33'd0, b});
    return p[47:16];
  endfunction

  // Control point times weight, same Q16.16 rule.
  function automatic logic signed [31:0] qmul_w(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
    logic signed [63:0] p;
    p = $signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b});
    return p[47:16];
  endfunction

endpackage

FILE: src/cubic_bezier_evaluator_core.sv
// Cubic Bezier evaluator, five stage pipeline with APB-style control point registers.
// Depends on cbe_pkg.
//
// One item is taken per clock while input ready is high; its result is offered from the
// output register once it has passed every stage. Three stages run one Horner step each on all
// four Bernstein weights, the fourth multiplies the control points by the weights and
// the fifth sums them into the output register. Each stage keeps its own valid bit,
// so a stall on the result side fills empty stages before input ready drops.
// Control points should only be written while no item is in flight.
module cubic_bezier_evaluator_core (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  cbe_pkg::in_item_t      in_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output cbe_pkg::out_item_t     out_data,
  input  logic                   cfg_psel,
  input  logic                   cfg_penable,
  input  logic                   cfg_pwrite,
  input  logic [cbe_pkg::ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]            cfg_pwdata,
  output logic [31:0]            cfg_prdata,
  output logic                   cfg_pready
);

  logic [31:0] cfg_r [cbe_pkg::NUM_REGS];
  logic        cfg_wr;

  logic [cbe_pkg::NUM_STG-1:0] vld_r;
  logic [cbe_pkg::NUM_STG-1:0] vld_nxt;
  logic [cbe_pkg::NUM_STG-1:0] adv;

  logic [1:0]         s1_kind_r, s2_kind_r;
  logic [16:0]        s1_t_r, s2_t_r;
  logic signed [31:0] s1_w_r [cbe_pkg::NUM_PTS];
  logic signed [31:0] s2_w_r [cbe_pkg::NUM_PTS];
  logic signed [31:0] s3_w_r [cbe_pkg::NUM_PTS];
  logic signed [31:0] s4_px_r [cbe_pkg::NUM_PTS];
  logic signed [31:0] s4_py_r [cbe_pkg::NUM_PTS];
  cbe_pkg::out_item_t out_r;

  // Configuration port.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_prdata = cfg_r[cfg_paddr[4:2]];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < cbe_pkg::NUM_REGS; i++) begin
        cfg_r[i] <= '0;
      end
    end else if (cfg_wr) begin
      cfg_r[cfg_paddr[4:2]] <= cfg_pwdata;
    end
  end

  // A stage may load when it is empty or its contents move on this cycle.
  always_comb begin
    adv[cbe_pkg::NUM_STG-1] = !vld_r[cbe_pkg::NUM_STG-1] || out_ready;
    for (int s = cbe_pkg::NUM_STG - 2; s >= 0; s--) begin
      adv[s] = !vld_r[s] || adv[s+1];
    end
    vld_nxt[0] = adv[0] ? in_valid : vld_r[0];
    for (int s = 1; s < cbe_pkg::NUM_STG; s++) begin
      vld_nxt[s] = adv[s] ? vld_r[s-1] : vld_r[s];
    end
  end

  assign in_ready  = adv[0];
  assign out_valid = vld_r[cbe_pkg::NUM_STG-1];
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // First Horner step.
  always_ff @(posedge clk) begin
    if (adv[0] && in_valid) begin
      s1_kind_r <= in_data.kind;
      s1_t_r    <= in_data.t;
      for (int i = 0; i < cbe_pkg::NUM_PTS; i++) begin
        s1_w_r[i] <= cbe_pkg::qmul_t(cbe_pkg::coef_q(in_data.kind, 2'(i), 2'd0), in_data.t)
                     + cbe_pkg::coef_q(in_data.kind, 2'(i), 2'd1);
      end
    end
  end

  // Second Horner step.
  always_ff @(posedge clk) begin
    if (adv[1] && vld_r[0]) begin
      s2_kind_r <= s1_kind_r;
      s2_t_r    <= s1_t_r;
      for (int i = 0; i < cbe_pkg::NUM_PTS; i++) begin
        s2_w_r[i] <= cbe_pkg::qmul_t(s1_w_r[i], s1_t_r)
                     + cbe_pkg::coef_q(s1_kind_r, 2'(i), 2'd2);
      end
    end
  end

  // Third Horner step gives the final weights.
  always_ff @(posedge clk) begin
    if (adv[2] && vld_r[1]) begin
      for (int i = 0; i < cbe_pkg::NUM_PTS; i++) begin
        s3_w_r[i] <= cbe_pkg::qmul_t(s2_w_r[i], s2_t_r)
                     + cbe_pkg::coef_q(s2_kind_r, 2'(i), 2'd3);
      end
    end
  end

  // Control points scaled by their weights.
  always_ff @(posedge clk) begin
    if (adv[3] && vld_r[2]) begin
      for (int i = 0; i < cbe_pkg::NUM_PTS; i++) begin
        s4_px_r[i] <= cbe_pkg::qmul_w(cfg_r[2*i], s3_w_r[i]);
        s4_py_r[i] <= cbe_pkg::qmul_w(cfg_r[2*i+1], s3_w_r[i]);
      end
    end
  end

  // Sums wrap modulo 2^32.
  always_ff @(posedge clk) begin
    if (adv[4] && vld_r[3]) begin
      out_r.out_x <= s4_px_r[0] + s4_px_r[1] + s4_px_r[2] + s4_px_r[3];
      out_r.out_y <= s4_py_r[0] + s4_py_r[1] + s4_py_r[2] + s4_py_r[3];
    end
  end

endmodule

FILE: src/cbe_checker.sv
// Port-level checks for the cubic Bezier evaluator, bound to the top level.
// Depends on cbe_pkg and cubic_bezier_evaluator_core_defines.svh.
`include "cubic_bezier_evaluator_core_defines.svh"

module cbe_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input cbe_pkg::out_item_t         out_data,
  input logic                       cfg_pready
);

  // The register port never inserts wait states.
  `CBE_ASSERT_IMP(a_pready_high, 1'b1, cfg_pready)

  // Reset empties the pipeline, so no result is offered just after it.
  `CBE_ASSERT_RST(a_reset_empty, !rst_n, !out_valid)

  // With the result side free or empty, every stage can move, so input is taken.
  `CBE_ASSERT_IMP(a_ready_flow, out_ready || !out_valid, in_ready)

  // A result that is not taken stays on offer unchanged.
  `CBE_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))

endmodule

bind cubic_bezier_evaluator_core cbe_checker u_cbe_checker (.*);
